### src/cba_pkg.sv
// Shared types, operation codes and helper functions of the integer binary ALU.
package cba_pkg;

  localparam int XLEN      = 64;
  localparam int HLEN      = 32;
  localparam int DIV_STEPS = XLEN;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_LAND = 5'd5,
    OP_LOR  = 5'd6,
    OP_BAND = 5'd7,
    OP_BOR  = 5'd8,
    OP_XOR  = 5'd9,
    OP_SHL  = 5'd10,
    OP_SHR  = 5'd11,
    OP_ASHR = 5'd12,
    OP_EQ   = 5'd13,
    OP_NE   = 5'd14,
    OP_LT   = 5'd15,
    OP_GT   = 5'd16,
    OP_LE   = 5'd17,
    OP_GE   = 5'd18
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_MOD_ZERO = 2'd2,
    ST_BAD_OP   = 2'd3
  } status_t;

  typedef struct packed {
    logic [4:0]      op;
    logic            sgn;
    logic            wide;
    logic            neg_q;
    logic            neg_r;
    logic [1:0]      st;
    logic [XLEN-1:0] res;
  } meta_t;

  function automatic logic [XLEN-1:0] fit_width(input logic [XLEN-1:0] v,
                                                input logic wide, input logic sgn);
    logic [XLEN-1:0] r;
    if (wide) begin
      r = v;
    end else begin
      r = {{(XLEN-HLEN){sgn & v[HLEN-1]}}, v[HLEN-1:0]};
    end
    return r;
  endfunction

  function automatic logic [XLEN-1:0] magnitude(input logic [XLEN-1:0] v);
    return v[XLEN-1] ? (~v + XLEN'(1)) : v;
  endfunction

endpackage

### src/cba_in_if.sv
// Input channel of the integer binary ALU: handshake and operand beat.
interface cba_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  operation;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic        a_unsigned;
  logic        a_long;
  logic        b_long;

  modport source (output valid, operation, operand_a, operand_b, a_unsigned, a_long,
                  b_long, input ready);
  modport sink (input valid, operation, operand_a, operand_b, a_unsigned, a_long,
                b_long, output ready);
endinterface

### src/cba_out_if.sv
// Result channel of the integer binary ALU: handshake and result beat.
interface cba_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result;
  logic [1:0]  status;

  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

### src/c_integer_binary_alu.sv
// Integer binary ALU with C semantics.
// Throughput is one beat per cycle while results are taken; every operation runs through the same pipeline.
// The depth is set by the one-bit-per-stage divider (64 stages) plus input, operand and
// output stages. A result that is not taken holds the whole pipeline.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
module c_integer_binary_alu
  import cba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  cba_in_if.sink   in_chan,
  cba_out_if.source out_chan
);

  logic en;
  assign en = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  // Input stage: operands cut and extended to the operation width.
  logic            s0_vld_r;
  logic [XLEN-1:0] s0_a_r, s0_b_r;
  logic [4:0]      s0_op_r;
  logic            s0_sgn_r, s0_wide_r;

  logic in_sgn, in_wide;
  assign in_sgn  = !in_chan.a_unsigned;
  assign in_wide = in_chan.a_long | in_chan.b_long;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_chan.valid;
    end
    if (en) begin
      s0_a_r    <= fit_width(in_chan.operand_a, in_wide, in_sgn);
      s0_b_r    <= fit_width(in_chan.operand_b, in_wide, in_sgn);
      s0_op_r   <= in_chan.operation;
      s0_sgn_r  <= in_sgn;
      s0_wide_r <= in_wide;
    end
  end

  // Operand stage: simple operations, partial products and divider set-up.
  logic [5:0]      sh;
  logic [XLEN-1:0] shr_val;
  logic            lt, gt, a_nz, b_nz;
  meta_t           p1_meta;

  assign sh      = s0_b_r[5:0] & (s0_wide_r ? 6'd63 : 6'd31);
  assign shr_val = s0_sgn_r ? XLEN'($signed(s0_a_r) >>> sh) : (s0_a_r >> sh);
  assign lt      = s0_sgn_r ? ($signed(s0_a_r) < $signed(s0_b_r)) : (s0_a_r < s0_b_r);
  assign gt      = s0_sgn_r ? ($signed(s0_b_r) < $signed(s0_a_r)) : (s0_b_r < s0_a_r);
  assign a_nz    = |s0_a_r;
  assign b_nz    = |s0_b_r;

  always_comb begin
    p1_meta       = '0;
    p1_meta.op    = s0_op_r;
    p1_meta.sgn   = s0_sgn_r;
    p1_meta.wide  = s0_wide_r;
    p1_meta.neg_q = s0_sgn_r & (s0_a_r[XLEN-1] ^ s0_b_r[XLEN-1]);
    p1_meta.neg_r = s0_sgn_r & s0_a_r[XLEN-1];
    p1_meta.st    = ST_OK;
    unique case (s0_op_r)
      OP_ADD:  p1_meta.res = s0_a_r + s0_b_r;
      OP_SUB:  p1_meta.res = s0_a_r - s0_b_r;
      OP_MUL:  p1_meta.res = '0;
      OP_DIV:  p1_meta.st  = b_nz ? ST_OK : ST_DIV_ZERO;
      OP_MOD:  p1_meta.st  = b_nz ? ST_OK : ST_MOD_ZERO;
      OP_LAND: p1_meta.res = XLEN'(a_nz && b_nz);
      OP_LOR:  p1_meta.res = XLEN'(a_nz || b_nz);
      OP_BAND: p1_meta.res = s0_a_r & s0_b_r;
      OP_BOR:  p1_meta.res = s0_a_r | s0_b_r;
      OP_XOR:  p1_meta.res = s0_a_r ^ s0_b_r;
      OP_SHL:  p1_meta.res = s0_a_r << sh;
      OP_SHR:  p1_meta.res = shr_val;
      OP_ASHR: p1_meta.res = shr_val;
      OP_EQ:   p1_meta.res = XLEN'(s0_a_r == s0_b_r);
      OP_NE:   p1_meta.res = XLEN'(s0_a_r != s0_b_r);
      OP_LT:   p1_meta.res = XLEN'(lt);
      OP_GT:   p1_meta.res = XLEN'(gt);
      OP_LE:   p1_meta.res = XLEN'(!gt);
      OP_GE:   p1_meta.res = XLEN'(!lt);
      default: p1_meta.st  = ST_BAD_OP;
    endcase
  end

  logic            vld_r [DIV_STEPS+1];
  meta_t           m_r   [DIV_STEPS+1];
  logic [XLEN-1:0] rem_r [DIV_STEPS+1];
  logic [XLEN-1:0] dq_r  [DIV_STEPS+1];
  logic [XLEN-1:0] dv_r  [DIV_STEPS+1];
  logic [XLEN-1:0] pp_ll_r;
  logic [HLEN-1:0] pp_lh_r, pp_hl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= s0_vld_r;
    end
    if (en) begin
      m_r[0]   <= p1_meta;
      rem_r[0] <= '0;
      dq_r[0]  <= s0_sgn_r ? magnitude(s0_a_r) : s0_a_r;
      dv_r[0]  <= s0_sgn_r ? magnitude(s0_b_r) : s0_b_r;
      pp_ll_r  <= s0_a_r[HLEN-1:0] * s0_b_r[HLEN-1:0];
      pp_lh_r  <= HLEN'(s0_a_r[HLEN-1:0] * s0_b_r[XLEN-1:HLEN]);
      pp_hl_r  <= HLEN'(s0_a_r[XLEN-1:HLEN] * s0_b_r[HLEN-1:0]);
    end
  end

  // Restoring divider: one quotient bit per stage.
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [XLEN:0]   trial;
    logic [XLEN:0]   diff;
    logic            take;
    meta_t           meta_nxt;

    assign trial = {rem_r[j-1], dq_r[j-1][XLEN-1]};
    assign diff  = trial - {1'b0, dv_r[j-1]};
    assign take  = !diff[XLEN];

    always_comb begin
      meta_nxt = m_r[j-1];
      if (j == 1 && m_r[j-1].op == OP_MUL) begin
        meta_nxt.res = pp_ll_r + {pp_lh_r + pp_hl_r, {HLEN{1'b0}}};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= vld_r[j-1];
      end
      if (en) begin
        m_r[j]   <= meta_nxt;
        rem_r[j] <= take ? diff[XLEN-1:0] : trial[XLEN-1:0];
        dq_r[j]  <= {dq_r[j-1][XLEN-2:0], take};
        dv_r[j]  <= dv_r[j-1];
      end
    end
  end

  // Output stage: sign correction and width fitting.
  meta_t           fm;
  logic [XLEN-1:0] fin_res;
  assign fm = m_r[DIV_STEPS];

  always_comb begin
    if (fm.st != ST_OK) begin
      fin_res = '0;
    end else if (fm.op == OP_DIV) begin
      fin_res = fm.neg_q ? (~dq_r[DIV_STEPS] + XLEN'(1)) : dq_r[DIV_STEPS];
    end else if (fm.op == OP_MOD) begin
      fin_res = fm.neg_r ? (~rem_r[DIV_STEPS] + XLEN'(1)) : rem_r[DIV_STEPS];
    end else begin
      fin_res = fm.res;
    end
  end

  logic            out_vld_r;
  logic [XLEN-1:0] out_res_r;
  logic [1:0]      out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[DIV_STEPS];
    end
    if (en) begin
      out_res_r <= fit_width(fin_res, fm.wide, fm.sgn);
      out_st_r  <= fm.st;
    end
  end

  assign out_chan.valid  = out_vld_r;
  assign out_chan.result = out_res_r;
  assign out_chan.status = out_st_r;

endmodule

### src/cba_checker.sv
// Port-level checks of the integer binary ALU and their binding to the top level.
module cba_checker
  import cba_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result,
  input logic [1:0]  out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("A waiting result beat changed or vanished.");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result == 64'd0)
    else $error("An error beat carries a nonzero result.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled without a blocked result.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid straight after reset.");

endmodule

bind c_integer_binary_alu cba_checker u_cba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_result (out_chan.result),
  .out_status (out_chan.status)
);

### bench/testbench.sv
// Self-checking testbench for the integer binary ALU: directed table, then random beats.
`timescale 1ns / 100ps

module testbench;
  import cba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic failed = 1'b0;

  cba_in_if in_chan();
  cba_out_if out_chan();

  c_integer_binary_alu DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan.sink),
    .out_chan(out_chan.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct {
    logic [4:0]  op;
    logic [63:0] a;
    logic [63:0] b;
    logic        uns;
    logic        al;
    logic        bl;
  } alu_req_t;

  typedef struct {
    logic [63:0] res;
    logic [1:0]  st;
  } alu_res_t;

  typedef struct {
    alu_req_t req;
    logic     fixed;
    alu_res_t res;
  } row_t;

  alu_res_t pending_results[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL1 = '1;
  localparam int LATENCY = 66;

  function automatic logic [63:0] extend(logic [63:0] v, logic wide, logic sgn);
    if (wide) return v;
    return {{32{sgn & v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic alu_res_t compute_alu(alu_req_t q);
    alu_res_t o;
    logic sgn, wide, arith, lt_ab, lt_ba;
    logic [63:0] a, b, qu, rm;
    int sh;
    sgn = ~q.uns;
    wide = q.al | q.bl;
    a = extend(q.a, wide, sgn);
    b = extend(q.b, wide, sgn);
    sh = wide ? int'(b[5:0]) : int'(b[4:0]);
    lt_ab = sgn ? ($signed(a) < $signed(b)) : (a < b);
    lt_ba = sgn ? ($signed(b) < $signed(a)) : (b < a);
    o.res = '0;
    o.st = ST_OK;
    arith = 1'b1;
    case (q.op)
      OP_ADD: o.res = a + b;
      OP_SUB: o.res = a - b;
      OP_MUL: o.res = a * b;
      OP_DIV, OP_MOD: begin
        arith = 1'b0;
        if (b == 0) begin
          o.st = (q.op == OP_DIV) ? ST_DIV_ZERO : ST_MOD_ZERO;
        end else begin
          arith = 1'b1;
          if (sgn) begin
            qu = abs64(a) / abs64(b);
            rm = abs64(a) % abs64(b);
            if (q.op == OP_DIV) o.res = (a[63] ^ b[63]) ? -qu : qu;
            else o.res = a[63] ? -rm : rm;
          end else begin
            o.res = (q.op == OP_DIV) ? a / b : a % b;
          end
        end
      end
      OP_LAND: begin o.res = 64'(a != 0 && b != 0); arith = 1'b0; end
      OP_LOR: begin o.res = 64'(a != 0 || b != 0); arith = 1'b0; end
      OP_BAND: o.res = a & b;
      OP_BOR: o.res = a | b;
      OP_XOR: o.res = a ^ b;
      OP_SHL: o.res = a << sh;
      OP_SHR, OP_ASHR: o.res = sgn ? 64'($signed(a) >>> sh) : a >> sh;
      OP_EQ: begin o.res = 64'(a == b); arith = 1'b0; end
      OP_NE: begin o.res = 64'(a != b); arith = 1'b0; end
      OP_LT: begin o.res = 64'(lt_ab); arith = 1'b0; end
      OP_GT: begin o.res = 64'(lt_ba); arith = 1'b0; end
      OP_LE: begin o.res = 64'(!lt_ba); arith = 1'b0; end
      OP_GE: begin o.res = 64'(!lt_ab); arith = 1'b0; end
      default: begin o.st = ST_BAD_OP; arith = 1'b0; end
    endcase
    if (arith) o.res = extend(o.res, wide, sgn);
    return o;
  endfunction

  task automatic send_beat(alu_req_t q, logic fixed, alu_res_t fixed_res);
    alu_res_t pr;
    pr = compute_alu(q);
    if (fixed && pr !== fixed_res) begin
      $display("%0t table row disagrees: op %0d expected %h/%0d, predicted %h/%0d", $time,
               q.op, fixed_res.res, fixed_res.st, pr.res, pr.st);
      failed = 1'b1;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.operation <= q.op;
    in_chan.operand_a <= q.a;
    in_chan.operand_b <= q.b;
    in_chan.a_unsigned <= q.uns;
    in_chan.a_long <= q.al;
    in_chan.b_long <= q.bl;
    do @(posedge clk); while (!in_chan.ready);
    pending_results.push_back(fixed ? fixed_res : pr);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0: v = 64'($urandom_range(4));
      1: v = -64'($urandom_range(4));
      2: v = $urandom_range(1) ? MIN64 : MAX64;
      3: v = {32'($urandom), 32'($urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff)};
      4: v = 64'($urandom_range(100));
      default: ;
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    out_chan.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    alu_res_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result %h status %0d", $time, out_chan.result,
                 out_chan.status);
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_chan.result !== e.res || out_chan.status !== e.st) begin
          $display("%0t mismatch: expected %h status %0d, actual %h status %0d", $time,
                   e.res, e.st, out_chan.result, out_chan.status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    row_t rows[$];
    alu_req_t q;
    alu_res_t none;
    int guard;
    none = '{res: '0, st: ST_OK};
    in_chan.valid = 1'b0;
    in_chan.operation = '0;
    in_chan.operand_a = '0;
    in_chan.operand_b = '0;
    in_chan.a_unsigned = 1'b0;
    in_chan.a_long = 1'b0;
    in_chan.b_long = 1'b0;
    out_chan.ready = 1'b0;

    rows = '{
      '{'{OP_ADD, MAX64, 64'd1, 1'b0, 1'b1, 1'b0}, 1'b1, '{MIN64, ST_OK}},
      '{'{OP_ADD, 64'h7fff_ffff, 64'd1, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{64'hffff_ffff_8000_0000, ST_OK}},
      '{'{OP_ADD, 64'hffff_ffff, 64'd1, 1'b1, 1'b0, 1'b0}, 1'b1, '{64'd0, ST_OK}},
      '{'{OP_SUB, 64'd0, 64'd1, 1'b1, 1'b1, 1'b1}, 1'b1, '{ALL1, ST_OK}},
      '{'{OP_MUL, ALL1, MIN64, 1'b0, 1'b0, 1'b1}, 1'b0, none},
      '{'{OP_DIV, MIN64, ALL1, 1'b0, 1'b1, 1'b1}, 1'b1, '{MIN64, ST_OK}},
      '{'{OP_MOD, MIN64, ALL1, 1'b0, 1'b1, 1'b1}, 1'b1, '{64'd0, ST_OK}},
      '{'{OP_DIV, 64'd7, 64'h1_0000_0000, 1'b0, 1'b0, 1'b0}, 1'b1, '{64'd0, ST_DIV_ZERO}},
      '{'{OP_MOD, 64'd7, 64'd0, 1'b1, 1'b1, 1'b0}, 1'b1, '{64'd0, ST_MOD_ZERO}},
      '{'{OP_DIV, -64'd7, 64'd2, 1'b0, 1'b1, 1'b0}, 1'b1, '{-64'd3, ST_OK}},
      '{'{OP_MOD, -64'd7, 64'd2, 1'b0, 1'b0, 1'b0}, 1'b1, '{ALL1, ST_OK}},
      '{'{OP_LAND, 64'h1_0000_0000, 64'd5, 1'b0, 1'b0, 1'b0}, 1'b1, '{64'd0, ST_OK}},
      '{'{OP_LOR, 64'h1_0000_0000, 64'd0, 1'b0, 1'b1, 1'b0}, 1'b1, '{64'd1, ST_OK}},
      '{'{OP_BAND, ALL1, MAX64, 1'b1, 1'b1, 1'b1}, 1'b0, none},
      '{'{OP_BOR, 64'h8000_0000, 64'd1, 1'b0, 1'b0, 1'b0}, 1'b0, none},
      '{'{OP_XOR, ALL1, MIN64, 1'b0, 1'b1, 1'b1}, 1'b0, none},
      '{'{OP_SHL, 64'd1, 64'd33, 1'b0, 1'b0, 1'b0}, 1'b1, '{64'd2, ST_OK}},
      '{'{OP_SHR, MIN64, 64'd63, 1'b0, 1'b1, 1'b0}, 1'b1, '{ALL1, ST_OK}},
      '{'{OP_ASHR, MIN64, 64'd63, 1'b1, 1'b1, 1'b0}, 1'b1, '{64'd1, ST_OK}},
      '{'{OP_EQ, 64'h5_0000_0001, 64'd1, 1'b0, 1'b0, 1'b0}, 1'b1, '{64'd1, ST_OK}},
      '{'{OP_NE, MIN64, MAX64, 1'b1, 1'b1, 1'b1}, 1'b1, '{64'd1, ST_OK}},
      '{'{OP_LT, MIN64, MAX64, 1'b0, 1'b1, 1'b1}, 1'b1, '{64'd1, ST_OK}},
      '{'{OP_GT, MIN64, MAX64, 1'b1, 1'b1, 1'b1}, 1'b1, '{64'd1, ST_OK}},
      '{'{OP_LE, ALL1, 64'd0, 1'b0, 1'b0, 1'b0}, 1'b1, '{64'd1, ST_OK}},
      '{'{OP_GE, ALL1, 64'd0, 1'b1, 1'b0, 1'b0}, 1'b1, '{64'd1, ST_OK}},
      '{'{5'd19, ALL1, ALL1, 1'b0, 1'b0, 1'b0}, 1'b1, '{64'd0, ST_BAD_OP}},
      '{'{5'd31, ALL1, ALL1, 1'b1, 1'b1, 1'b1}, 1'b1, '{64'd0, ST_BAD_OP}}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_beat(rows[i].req, rows[i].fixed, rows[i].res);

    for (int n = 0; n < 1050; n++) begin
      if (n == 350) begin
        send_idle_pct = 70;
        recv_idle_pct = 21;
      end else if (n == 700) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n == 0) begin
        send_idle_pct = 21;
        recv_idle_pct = 70;
      end
      if (n == 500) begin
        in_chan.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      q.op = ($urandom_range(15) == 0) ? 5'($urandom_range(31, 19)) : 5'($urandom_range(18));
      q.a = rand_operand();
      q.b = ($urandom_range(9) == 0) ? 64'({$urandom_range(1), 32'd0}) : rand_operand();
      q.uns = 1'($urandom);
      q.al = 1'($urandom);
      q.bl = 1'($urandom);
      send_beat(q, 1'b0, none);
    end
    in_chan.valid <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 200_000) begin
      @(negedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(negedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t %0d results never arrived", $time, pending_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
